@@ design/bkvs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bkvs_pkg
// Shared widths, codes and transaction types of the bottom-k vertex sampler.
// ----------------------------------------------------------------------------
package bkvs_pkg;

   localparam int CAPACITY          = 1024;
   localparam int VERTEX_WIDTH      = 64;
   localparam int HASH_WIDTH        = 64;
   localparam int SALT_WIDTH        = 31;
   localparam int SIZE_WIDTH        = 11;
   localparam int FIELD_COUNT_WIDTH = 11;
   localparam int COUNT_WIDTH       = $clog2(CAPACITY + 1);
   localparam int CMP_WIDTH         = (COUNT_WIDTH > SIZE_WIDTH) ? COUNT_WIDTH : SIZE_WIDTH;

   // OR tree over the cell row: two registered levels
   localparam int GROUP_SIZE = 32;
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HASH_SALT   = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLE_SIZE = CSR_INDEX_WIDTH'(1);
   localparam logic [SIZE_WIDTH-1:0]      SAMPLE_SIZE_RESET = SIZE_WIDTH'(1024);

   // commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_FILTER = 1'b1;

   // integer-mix hash shift amounts
   localparam int MIX_SHL_A = 21;
   localparam int MIX_SHR_A = 24;
   localparam int MIX_SHL_B = 3;
   localparam int MIX_SHL_C = 8;
   localparam int MIX_SHR_B = 14;
   localparam int MIX_SHL_D = 2;
   localparam int MIX_SHL_E = 4;
   localparam int MIX_SHR_C = 28;
   localparam int MIX_SHL_F = 31;

   typedef struct packed {
      logic                    command;
      logic [VERTEX_WIDTH-1:0] src_vertex;
      logic [VERTEX_WIDTH-1:0] dst_vertex;
   } req_payload_type;

   typedef struct packed {
      logic                         keep_edge;
      logic [FIELD_COUNT_WIDTH-1:0] sample_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [HASH_WIDTH-1:0]   hash;
      logic [VERTEX_WIDTH-1:0] vertex;
   } cell_entry_type;

   typedef struct packed {
      logic [HASH_WIDTH-1:0]   hash;
      logic [VERTEX_WIDTH-1:0] vertex;
      logic [HASH_WIDTH-1:0]   guard;
   } probe_type;

   typedef struct packed {
      logic insert;
      logic grow;
   } cell_ctrl_type;

   typedef struct packed {
      logic hit_hash;
      logic hit_vertex;
      logic above;
      logic max_guard;
   } cell_flags_type;

endpackage
`default_nettype wire

@@ design/bottom_k_vertex_sampler_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bottom_k_vertex_sampler_unit
// Keeps the sample_size vertices of an edge stream with the smallest salted
// hashes and filters edges against that sample. The sample lives in a row of
// CAPACITY cells kept sorted by hash; a probe is broadcast to every cell, the
// compare flags are collected by a two-level registered OR tree, and an insert
// shifts the row by one cell toward the tail. One transaction is worked at a
// time: a sample edge passes through the hash pipeline, then for each
// endpoint through compare, two tree levels and the shift, and then loads
// the result register; a filter edge probes its source vertex without
// waiting for the hash. The block then returns to idle before it takes the
// next transaction, and stays busy while a stalled response still holds the
// result register. Write csr registers only while the block is idle. No
// clearing pass is needed after reset: cell valid bits clear at once.
// ----------------------------------------------------------------------------
module bottom_k_vertex_sampler_unit
   import bkvs_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire req_payload_type            req_payload,
   // response channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rsp_payload_type                 rsp_payload,
   // configuration write channel
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_HASH   = 3'd1;
   localparam logic [2:0] S_PROBE  = 3'd2;
   localparam logic [2:0] S_APPLY  = 3'd3;
   localparam logic [2:0] S_RESULT = 3'd4;

   // cycles to wait for hash outputs and for the flag tree
   localparam logic [1:0] HASH_WAIT  = 2'd3;
   localparam logic [1:0] PROBE_WAIT = 2'd2;

   logic [2:0]             state_ff, state_in;
   logic [1:0]             wait_ff, wait_in;
   logic                   phase_ff, phase_in;
   logic                   command_ff, command_in;
   logic [VERTEX_WIDTH-1:0] src_ff, src_in;
   logic [VERTEX_WIDTH-1:0] dst_ff, dst_in;
   logic                   held_src_ff, held_src_in;
   logic                   guard_en_ff, guard_en_in;
   probe_type              probe_ff, probe_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [SALT_WIDTH-1:0]  salt_ff, salt_in;
   logic [SIZE_WIDTH-1:0]  size_ff, size_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_payload_ff, rsp_payload_in;

   logic [HASH_WIDTH-1:0]  src_hash, dst_hash;
   logic [CMP_WIDTH-1:0]   limit;
   logic                   full;
   cell_ctrl_type          ctrl;
   cell_flags_type         tree_flags;
   probe_type              cell_probe;

   cell_entry_type [CAPACITY-1:0] cell_entry;
   logic           [CAPACITY-1:0] cell_valid;
   logic           [CAPACITY-1:0] cell_above;
   cell_flags_type [CAPACITY-1:0] cell_flags;

   // ---------------------------------------------------------------------
   // Hash both endpoints in parallel from the held request.
   // ---------------------------------------------------------------------
   bkvs_hash u_src_hash (
      .clock  (clock),
      .vertex (src_ff),
      .salt   (salt_ff),
      .hash   (src_hash)
   );

   bkvs_hash u_dst_hash (
      .clock  (clock),
      .vertex (dst_ff),
      .salt   (salt_ff),
      .hash   (dst_hash)
   );

   // ---------------------------------------------------------------------
   // Sorted row of sample cells. Cell 0 holds the smallest hash; the valid
   // cells form a prefix, so the last valid cell holds the maximum. The head
   // cell sees a valid left neighbor that never sorts above the probe, the
   // tail cell an empty right neighbor.
   // ---------------------------------------------------------------------
   // the guard compare only counts once the second endpoint is probed
   always_comb begin
      cell_probe = probe_ff;
      if (!guard_en_ff) begin
         cell_probe.guard = ~src_hash;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_entry_type left_entry;
      logic           left_valid;
      logic           left_above;
      logic           right_valid;

      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_valid = 1'b1;
         assign left_above = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_above = cell_above[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_valid = 1'b0;
      end else begin : g_next
         assign right_valid = cell_valid[i+1];
      end

      bkvs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .probe       (cell_probe),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .left_valid  (left_valid),
         .left_above  (left_above),
         .right_valid (right_valid),
         .cell_entry  (cell_entry[i]),
         .cell_valid  (cell_valid[i]),
         .cell_above  (cell_above[i]),
         .flags       (cell_flags[i])
      );
   end

   bkvs_or_tree u_or_tree (
      .clock     (clock),
      .flags_in  (cell_flags),
      .flags_out (tree_flags)
   );

   // ---------------------------------------------------------------------
   // Effective sample limit: zero counts as one, saturate at the row size.
   // A count above the limit (limit lowered) still counts as full.
   // ---------------------------------------------------------------------
   always_comb begin
      logic [CMP_WIDTH-1:0] size_ext;
      size_ext = CMP_WIDTH'(size_ff);
      if (size_ff == '0) begin
         limit = CMP_WIDTH'(1);
      end else if (size_ext > CMP_WIDTH'(CAPACITY)) begin
         limit = CMP_WIDTH'(CAPACITY);
      end else begin
         limit = size_ext;
      end
      full = CMP_WIDTH'(count_ff) >= limit;
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in       = state_ff;
      wait_in        = wait_ff;
      phase_in       = phase_ff;
      command_in     = command_ff;
      src_in         = src_ff;
      dst_in         = dst_ff;
      held_src_in    = held_src_ff;
      guard_en_in    = guard_en_ff;
      probe_in       = probe_ff;
      count_in       = count_ff;
      rsp_payload_in = rsp_payload_ff;
      ctrl           = '0;
      // drop the response once it is taken
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               command_in  = req_payload.command;
               src_in      = req_payload.src_vertex;
               dst_in      = req_payload.dst_vertex;
               phase_in    = 1'b0;
               guard_en_in = 1'b0;
               if (req_payload.command == CMD_FILTER) begin
                  // filter needs no hash: probe the source vertex at once
                  probe_in.vertex = req_payload.src_vertex;
                  wait_in         = PROBE_WAIT;
                  state_in        = S_PROBE;
               end else begin
                  wait_in  = HASH_WAIT;
                  state_in = S_HASH;
               end
            end
         end

         S_HASH: begin
            if (wait_ff == '0) begin
               probe_in.hash   = src_hash;
               probe_in.vertex = src_ff;
               probe_in.guard  = src_hash;
               wait_in         = PROBE_WAIT;
               state_in        = S_PROBE;
            end else begin
               wait_in = wait_ff - 2'd1;
            end
         end

         S_PROBE: begin
            // hold while flags travel through the cell row and the tree
            if (wait_ff == '0) begin
               state_in = S_APPLY;
            end else begin
               wait_in = wait_ff - 2'd1;
            end
         end

         S_APPLY: begin
            if (command_ff == CMD_SAMPLE) begin
               if (!(tree_flags.hit_hash || tree_flags.hit_vertex)) begin
                  if (!full) begin
                     ctrl.insert = 1'b1;
                     ctrl.grow   = 1'b1;
                     count_in    = count_ff + COUNT_WIDTH'(1);
                  end else if (tree_flags.above &&
                               !(guard_en_ff && tree_flags.max_guard)) begin
                     // replace the maximum: shift without growing
                     ctrl.insert = 1'b1;
                  end
               end
            end else if (!phase_ff) begin
               held_src_in = tree_flags.hit_vertex;
            end

            if (!phase_ff) begin
               // advance to the destination endpoint
               phase_in        = 1'b1;
               guard_en_in     = 1'b1;
               probe_in.hash   = dst_hash;
               probe_in.vertex = dst_ff;
               probe_in.guard  = src_hash;
               wait_in         = PROBE_WAIT;
               state_in        = S_PROBE;
            end else begin
               // hold the edge verdict until the output register is free
               held_src_in = (command_ff == CMD_FILTER) &&
                             held_src_ff && tree_flags.hit_vertex;
               state_in    = S_RESULT;
            end
         end

         S_RESULT: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_payload_in.keep_edge    = held_src_ff;
               rsp_payload_in.sample_count = FIELD_COUNT_WIDTH'(count_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      salt_in = salt_ff;
      size_in = size_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HASH_SALT:   salt_in = csr_data[SALT_WIDTH-1:0];
            CSR_SAMPLE_SIZE: size_in = csr_data[SIZE_WIDTH-1:0];
            default: begin
               salt_in = salt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wait_ff      <= '0;
         phase_ff     <= 1'b0;
         guard_en_ff  <= 1'b0;
         count_ff     <= '0;
         salt_ff      <= '0;
         size_ff      <= SAMPLE_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         phase_ff     <= phase_in;
         guard_en_ff  <= guard_en_in;
         count_ff     <= count_in;
         salt_ff      <= salt_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      command_ff     <= command_in;
      src_ff         <= src_in;
      dst_ff         <= dst_in;
      held_src_ff    <= held_src_in;
      probe_ff       <= probe_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire

@@ design/bkvs_hash.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bkvs_hash
// Three-stage pipeline of the salted 64-bit integer-mix vertex hash.
// ----------------------------------------------------------------------------
module bkvs_hash
   import bkvs_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic [VERTEX_WIDTH-1:0] vertex,
   input  wire logic [SALT_WIDTH-1:0]   salt,
   output logic      [HASH_WIDTH-1:0]   hash
);

   logic [HASH_WIDTH-1:0] stage1_ff, stage1_in;
   logic [HASH_WIDTH-1:0] stage2_ff, stage2_in;
   logic [HASH_WIDTH-1:0] stage3_ff, stage3_in;

   always_comb begin
      logic [HASH_WIDTH-1:0] a1, a3, a5, a6;
      a1 = (~vertex) + (vertex << MIX_SHL_A) + HASH_WIDTH'(salt);
      stage1_in = a1 ^ (a1 >> MIX_SHR_A);
      a3 = stage1_ff + (stage1_ff << MIX_SHL_B) + (stage1_ff << MIX_SHL_C);
      stage2_in = a3 ^ (a3 >> MIX_SHR_B);
      a5 = stage2_ff + (stage2_ff << MIX_SHL_D) + (stage2_ff << MIX_SHL_E);
      a6 = a5 ^ (a5 >> MIX_SHR_C);
      stage3_in = a6 + (a6 << MIX_SHL_F);
   end

   always_ff @(posedge clock) begin
      stage1_ff <= stage1_in;
      stage2_ff <= stage2_in;
      stage3_ff <= stage3_in;
   end

   assign hash = stage3_ff;

endmodule
`default_nettype wire

@@ design/bkvs_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bkvs_cell
// One slot of the sorted sample row: compares against the probe and shifts in.
// ----------------------------------------------------------------------------
module bkvs_cell
   import bkvs_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire probe_type      probe,
   input  wire cell_ctrl_type  ctrl,
   input  wire cell_entry_type left_entry,
   input  wire logic           left_valid,
   input  wire logic           left_above,
   input  wire logic           right_valid,
   output cell_entry_type      cell_entry,
   output logic                cell_valid,
   output logic                cell_above,
   output cell_flags_type      flags
);

   cell_entry_type entry_ff, entry_in;
   logic           valid_ff, valid_in;
   logic           above_ff, above_in;
   cell_flags_type flags_ff, flags_in;

   always_comb begin
      logic greater;
      greater  = entry_ff.hash > probe.hash;
      // an empty slot sorts above every hash
      above_in = !valid_ff || greater;
      flags_in.hit_hash   = valid_ff && (entry_ff.hash == probe.hash);
      flags_in.hit_vertex = valid_ff && (entry_ff.vertex == probe.vertex);
      flags_in.above      = valid_ff && greater;
      flags_in.max_guard  = valid_ff && !right_valid && (entry_ff.hash == probe.guard);

      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.insert) begin
         if (above_ff) begin
            entry_in = left_above ? left_entry :
                       cell_entry_type'{hash: probe.hash, vertex: probe.vertex};
         end
         // on replace the valid bits stay as they are, so the old maximum leaves the sample
         if (ctrl.grow) begin
            valid_in = valid_ff | left_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      above_ff <= above_in;
      flags_ff <= flags_in;
   end

   assign cell_entry = entry_ff;
   assign cell_valid = valid_ff;
   assign cell_above = above_ff;
   assign flags      = flags_ff;

endmodule
`default_nettype wire

@@ design/bkvs_or_tree.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bkvs_or_tree
// Two-level registered OR reduction of the per-cell compare flags.
// ----------------------------------------------------------------------------
module bkvs_or_tree
   import bkvs_pkg::*;
(
   input  wire logic                          clock,
   input  wire cell_flags_type [CAPACITY-1:0] flags_in,
   output cell_flags_type                     flags_out
);

   cell_flags_type [NUM_GROUPS-1:0] group_ff, group_in;
   cell_flags_type                  total_ff, total_in;

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (g * GROUP_SIZE + j < CAPACITY) begin
               group_in[g] = group_in[g] | flags_in[g * GROUP_SIZE + j];
            end
         end
      end
      total_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         total_in = total_in | group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      total_ff <= total_in;
   end

   assign flags_out = total_ff;

endmodule
`default_nettype wire
